// ===== rtl/ffha_pkg.sv =====
`default_nettype none

package ffha_pkg;

    localparam int DESC_COUNT = 64;
    localparam int ADDR_W     = 32;
    localparam int IDX_W      = (DESC_COUNT > 1) ? $clog2(DESC_COUNT) : 1;
    localparam int LNK_W      = $clog2(DESC_COUNT + 1);
    localparam logic [LNK_W-1:0] NIL = LNK_W'(DESC_COUNT);

    localparam logic [2:0] ST_OK        = 3'd0;
    localparam logic [2:0] ST_BAD_SIZE  = 3'd1;
    localparam logic [2:0] ST_NO_SPARE  = 3'd2;
    localparam logic [2:0] ST_NO_FIT    = 3'd3;
    localparam logic [2:0] ST_NOT_FOUND = 3'd4;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    typedef struct packed {
        logic [LNK_W-1:0]  link;
        logic [ADDR_W-1:0] size;
        logic [ADDR_W-1:0] base;
    } t_desc;

    typedef struct packed {
        logic [IDX_W-1:0] rd_idx;
        logic             we;
        logic [IDX_W-1:0] wr_idx;
        t_desc            wr_data;
    } t_mem_req;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DECODE,
        S_A_SPR,
        S_A_WALK,
        S_A_WRF,
        S_F_WALK,
        S_F_PUSH,
        S_C_LDCUR,
        S_C_INNER,
        S_C_WPREV,
        S_C_WCUR,
        S_DONE
    } t_state;

    function automatic t_desc desc_default(input logic [IDX_W-1:0] idx,
                                           input logic [ADDR_W-1:0] hb,
                                           input logic [ADDR_W-1:0] hs);
        t_desc d;
        d.base = '0;
        d.size = '0;
        if (idx == '0) begin
            d.link = NIL;
            d.base = hb;
            d.size = hs;
        end else if ((LNK_W'(idx) + LNK_W'(1)) < NIL) begin
            d.link = LNK_W'(idx) + LNK_W'(1);
        end else begin
            d.link = NIL;
        end
        return d;
    endfunction

endpackage

`default_nettype wire

// ===== rtl/ffha_ram.sv =====
`default_nettype none

module ffha_ram #(
    parameter int DEPTH = 64,
    parameter int WIDTH = 8
) (
    input  wire                      i_clk,
    input  wire  [$clog2(DEPTH)-1:0] i_rd_addr,
    input  wire                      i_we,
    input  wire  [$clog2(DEPTH)-1:0] i_wr_addr,
    input  wire  [WIDTH-1:0]         i_wr_data,
    output logic [WIDTH-1:0]         o_rd_data
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_we && (i_wr_addr == i_rd_addr)) begin
            o_rd_data <= i_wr_data;
        end else begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/ffha_store.sv =====
`default_nettype none

module ffha_store (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_init,
    input  wire  [ffha_pkg::ADDR_W-1:0]  i_heap_base,
    input  wire  [ffha_pkg::ADDR_W-1:0]  i_heap_size,
    input  wire  ffha_pkg::t_mem_req     i_req,
    output ffha_pkg::t_desc              o_q
);

    logic [ffha_pkg::DESC_COUNT-1:0] r_valid;
    logic                            r_rd_v;
    logic [ffha_pkg::IDX_W-1:0]      r_rd_idx;
    logic [$bits(ffha_pkg::t_desc)-1:0] ram_q;

    ffha_ram #(
        .DEPTH (ffha_pkg::DESC_COUNT),
        .WIDTH ($bits(ffha_pkg::t_desc))
    ) u_ram (
        .i_clk     (i_clk),
        .i_rd_addr (i_req.rd_idx),
        .i_we      (i_req.we),
        .i_wr_addr (i_req.wr_idx),
        .i_wr_data (i_req.wr_data),
        .o_rd_data (ram_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_init) begin
            r_valid <= '0;
        end else if (i_req.we) begin
            r_valid[i_req.wr_idx] <= 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        r_rd_idx <= i_req.rd_idx;
        r_rd_v   <= r_valid[i_req.rd_idx]
                    | (i_req.we && (i_req.wr_idx == i_req.rd_idx));
    end

    assign o_q = r_rd_v ? ffha_pkg::t_desc'(ram_q)
                        : ffha_pkg::desc_default(r_rd_idx, i_heap_base, i_heap_size);

endmodule

`default_nettype wire

// ===== rtl/ffha_engine.sv =====
`default_nettype none

module ffha_engine (
    input  wire                          i_clk,
    input  wire                          i_rst_n,
    input  wire                          i_init,
    input  wire                          i_req_valid,
    output logic                         o_req_ready,
    input  wire                          i_action,
    input  wire  [ffha_pkg::ADDR_W-1:0]  i_size,
    input  wire  [ffha_pkg::ADDR_W-1:0]  i_addr,
    output logic                         o_res_valid,
    input  wire                          i_res_ready,
    output logic [2:0]                   o_status,
    output logic [ffha_pkg::ADDR_W-1:0]  o_region,
    output ffha_pkg::t_mem_req           o_mem,
    input  wire  ffha_pkg::t_desc        i_q
);

    localparam int AW = ffha_pkg::ADDR_W;
    localparam int LW = ffha_pkg::LNK_W;
    localparam int IW = ffha_pkg::IDX_W;

    ffha_pkg::t_state r_state, n_state;
    logic [LW-1:0] r_free_head, n_free_head;
    logic [LW-1:0] r_out_head, n_out_head;
    logic [LW-1:0] r_spare_head, n_spare_head;

    logic             r_action, n_action;
    logic [AW-1:0]    r_size, n_size;
    logic [AW-1:0]    r_addr, n_addr;
    logic [AW-1:0]    r_need, n_need;
    logic [IW-1:0]    r_d, n_d;
    logic [IW-1:0]    r_f, n_f;
    logic [IW-1:0]    r_cur, n_cur;
    logic [IW-1:0]    r_cmp, n_cmp;
    logic [LW-1:0]    r_prev, n_prev;
    logic [LW-1:0]    r_nxt, n_nxt;
    ffha_pkg::t_desc  r_d_ent, n_d_ent;
    ffha_pkg::t_desc  r_f_ent, n_f_ent;
    ffha_pkg::t_desc  r_c, n_c;
    ffha_pkg::t_desc  r_p, n_p;
    logic [2:0]       r_status, n_status;
    logic [AW-1:0]    r_region, n_region;

    logic [1:0]  pad;
    logic [AW:0] need_ext;
    logic        absorb;
    logic        fit;
    logic        match;
    logic [LW-1:0] outer_next;

    assign pad        = 2'(3'd4 - {1'b0, r_size[1:0]});
    assign need_ext   = {1'b0, r_size} + (AW+1)'(pad);
    assign fit        = i_q.size > r_need;
    assign match      = i_q.base == r_addr;
    assign absorb     = (r_cmp != r_cur) && ((r_c.base + r_c.size) == i_q.base);
    assign outer_next = r_c.link;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_init) begin
            r_state      <= ffha_pkg::S_IDLE;
            r_free_head  <= '0;
            r_out_head   <= ffha_pkg::NIL;
            r_spare_head <= LW'(1);
        end else begin
            r_state      <= n_state;
            r_free_head  <= n_free_head;
            r_out_head   <= n_out_head;
            r_spare_head <= n_spare_head;
        end
    end

    always_ff @(posedge i_clk) begin
        r_action <= n_action;
        r_size   <= n_size;
        r_addr   <= n_addr;
        r_need   <= n_need;
        r_d      <= n_d;
        r_f      <= n_f;
        r_cur    <= n_cur;
        r_cmp    <= n_cmp;
        r_prev   <= n_prev;
        r_nxt    <= n_nxt;
        r_d_ent  <= n_d_ent;
        r_f_ent  <= n_f_ent;
        r_c      <= n_c;
        r_p      <= n_p;
        r_status <= n_status;
        r_region <= n_region;
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ffha_pkg::S_IDLE:
                if (i_req_valid) n_state = ffha_pkg::S_DECODE;
            ffha_pkg::S_DECODE: begin
                if (r_action == ffha_pkg::ACT_ALLOC) begin
                    if ((r_size == '0) || need_ext[AW] || (r_spare_head == ffha_pkg::NIL))
                        n_state = ffha_pkg::S_DONE;
                    else
                        n_state = ffha_pkg::S_A_SPR;
                end else begin
                    if ((r_addr == '0) || (r_out_head == ffha_pkg::NIL))
                        n_state = ffha_pkg::S_DONE;
                    else
                        n_state = ffha_pkg::S_F_WALK;
                end
            end
            ffha_pkg::S_A_SPR:
                n_state = (r_free_head == ffha_pkg::NIL) ? ffha_pkg::S_DONE
                                                         : ffha_pkg::S_A_WALK;
            ffha_pkg::S_A_WALK: begin
                if (fit)
                    n_state = ffha_pkg::S_A_WRF;
                else if (i_q.link == ffha_pkg::NIL)
                    n_state = ffha_pkg::S_DONE;
            end
            ffha_pkg::S_A_WRF:
                n_state = ffha_pkg::S_DONE;
            ffha_pkg::S_F_WALK: begin
                if (match)
                    n_state = ffha_pkg::S_F_PUSH;
                else if (i_q.link == ffha_pkg::NIL)
                    n_state = ffha_pkg::S_DONE;
            end
            ffha_pkg::S_F_PUSH:
                n_state = ffha_pkg::S_C_LDCUR;
            ffha_pkg::S_C_LDCUR:
                n_state = ffha_pkg::S_C_INNER;
            ffha_pkg::S_C_INNER: begin
                if (absorb)
                    n_state = ffha_pkg::S_C_WPREV;
                else if ((i_q.link == ffha_pkg::NIL) && (outer_next == ffha_pkg::NIL))
                    n_state = ffha_pkg::S_DONE;
                else if (i_q.link == ffha_pkg::NIL)
                    n_state = ffha_pkg::S_C_LDCUR;
            end
            ffha_pkg::S_C_WPREV:
                n_state = ffha_pkg::S_C_WCUR;
            ffha_pkg::S_C_WCUR: begin
                if ((r_nxt == ffha_pkg::NIL) && (outer_next == ffha_pkg::NIL))
                    n_state = ffha_pkg::S_DONE;
                else if (r_nxt == ffha_pkg::NIL)
                    n_state = ffha_pkg::S_C_LDCUR;
                else
                    n_state = ffha_pkg::S_C_INNER;
            end
            ffha_pkg::S_DONE:
                if (i_res_ready) n_state = ffha_pkg::S_IDLE;
            default:
                n_state = ffha_pkg::S_IDLE;
        endcase
    end

    always_comb begin
        n_free_head  = r_free_head;
        n_out_head   = r_out_head;
        n_spare_head = r_spare_head;
        n_action = r_action;
        n_size   = r_size;
        n_addr   = r_addr;
        n_need   = r_need;
        n_d      = r_d;
        n_f      = r_f;
        n_cur    = r_cur;
        n_cmp    = r_cmp;
        n_prev   = r_prev;
        n_nxt    = r_nxt;
        n_d_ent  = r_d_ent;
        n_f_ent  = r_f_ent;
        n_c      = r_c;
        n_p      = r_p;
        n_status = r_status;
        n_region = r_region;
        o_mem.rd_idx  = r_cur;
        o_mem.we      = 1'b0;
        o_mem.wr_idx  = r_cur;
        o_mem.wr_data = r_c;
        o_req_ready   = 1'b0;
        o_res_valid   = 1'b0;

        unique case (r_state)
            ffha_pkg::S_IDLE: begin
                o_req_ready = 1'b1;
                n_action = i_action;
                n_size   = i_size;
                n_addr   = i_addr;
            end
            ffha_pkg::S_DECODE: begin
                n_region = '0;
                n_status = ffha_pkg::ST_OK;
                if (r_action == ffha_pkg::ACT_ALLOC) begin
                    n_need = need_ext[AW-1:0];
                    n_d    = r_spare_head[IW-1:0];
                    o_mem.rd_idx = r_spare_head[IW-1:0];
                    if ((r_size == '0) || need_ext[AW])
                        n_status = ffha_pkg::ST_BAD_SIZE;
                    else if (r_spare_head == ffha_pkg::NIL)
                        n_status = ffha_pkg::ST_NO_SPARE;
                end else begin
                    n_cur  = r_out_head[IW-1:0];
                    n_prev = ffha_pkg::NIL;
                    o_mem.rd_idx = r_out_head[IW-1:0];
                    if ((r_addr != '0) && (r_out_head == ffha_pkg::NIL))
                        n_status = ffha_pkg::ST_NOT_FOUND;
                end
            end
            ffha_pkg::S_A_SPR: begin
                n_d_ent = i_q;
                n_f     = r_free_head[IW-1:0];
                o_mem.rd_idx = r_free_head[IW-1:0];
                if (r_free_head == ffha_pkg::NIL)
                    n_status = ffha_pkg::ST_NO_FIT;
                else
                    n_spare_head = i_q.link;
            end
            ffha_pkg::S_A_WALK: begin
                o_mem.rd_idx = i_q.link[IW-1:0];
                n_f = i_q.link[IW-1:0];
                if (fit) begin
                    o_mem.we           = 1'b1;
                    o_mem.wr_idx       = r_d;
                    o_mem.wr_data.link = r_out_head;
                    o_mem.wr_data.size = r_need;
                    o_mem.wr_data.base = i_q.base + i_q.size - r_need;
                    n_region     = i_q.base + i_q.size - r_need;
                    n_out_head   = LW'(r_d);
                    n_f_ent.link = i_q.link;
                    n_f_ent.size = i_q.size - r_need;
                    n_f_ent.base = i_q.base;
                    n_f          = r_f;
                end else if (i_q.link == ffha_pkg::NIL) begin
                    o_mem.we           = 1'b1;
                    o_mem.wr_idx       = r_d;
                    o_mem.wr_data      = r_d_ent;
                    o_mem.wr_data.link = r_spare_head;
                    n_spare_head = LW'(r_d);
                    n_status     = ffha_pkg::ST_NO_FIT;
                end
            end
            ffha_pkg::S_A_WRF: begin
                o_mem.we      = 1'b1;
                o_mem.wr_idx  = r_f;
                o_mem.wr_data = r_f_ent;
            end
            ffha_pkg::S_F_WALK: begin
                o_mem.rd_idx = i_q.link[IW-1:0];
                if (match) begin
                    if (r_prev != ffha_pkg::NIL) begin
                        o_mem.we           = 1'b1;
                        o_mem.wr_idx       = r_prev[IW-1:0];
                        o_mem.wr_data      = r_p;
                        o_mem.wr_data.link = i_q.link;
                    end else begin
                        n_out_head = i_q.link;
                    end
                    n_c      = i_q;
                    n_c.link = r_free_head;
                end else if (i_q.link == ffha_pkg::NIL) begin
                    n_status = ffha_pkg::ST_NOT_FOUND;
                end else begin
                    n_prev = LW'(r_cur);
                    n_p    = i_q;
                    n_cur  = i_q.link[IW-1:0];
                end
            end
            ffha_pkg::S_F_PUSH: begin
                o_mem.we      = 1'b1;
                o_mem.wr_idx  = r_cur;
                o_mem.wr_data = r_c;
                o_mem.rd_idx  = r_cur;
                n_free_head   = LW'(r_cur);
            end
            ffha_pkg::S_C_LDCUR: begin
                n_c    = i_q;
                n_prev = ffha_pkg::NIL;
                n_cmp  = r_free_head[IW-1:0];
                o_mem.rd_idx = r_free_head[IW-1:0];
            end
            ffha_pkg::S_C_INNER: begin
                n_nxt = i_q.link;
                if (absorb) begin
                    o_mem.we           = 1'b1;
                    o_mem.wr_idx       = r_cmp;
                    o_mem.wr_data      = i_q;
                    o_mem.wr_data.link = r_spare_head;
                    n_spare_head = LW'(r_cmp);
                    n_c.size     = r_c.size + i_q.size;
                    if (r_prev == LW'(r_cur))
                        n_c.link = i_q.link;
                    if (r_prev == ffha_pkg::NIL)
                        n_free_head = i_q.link;
                end else begin
                    n_prev = LW'(r_cmp);
                    n_p    = i_q;
                    if (i_q.link != ffha_pkg::NIL) begin
                        n_cmp = i_q.link[IW-1:0];
                        o_mem.rd_idx = i_q.link[IW-1:0];
                    end else begin
                        n_cur = outer_next[IW-1:0];
                        o_mem.rd_idx = outer_next[IW-1:0];
                    end
                end
            end
            ffha_pkg::S_C_WPREV: begin
                if ((r_prev != ffha_pkg::NIL) && (r_prev != LW'(r_cur))) begin
                    o_mem.we           = 1'b1;
                    o_mem.wr_idx       = r_prev[IW-1:0];
                    o_mem.wr_data      = r_p;
                    o_mem.wr_data.link = r_nxt;
                    n_p.link = r_nxt;
                end
            end
            ffha_pkg::S_C_WCUR: begin
                o_mem.we      = 1'b1;
                o_mem.wr_idx  = r_cur;
                o_mem.wr_data = r_c;
                if (r_nxt != ffha_pkg::NIL) begin
                    n_cmp = r_nxt[IW-1:0];
                    o_mem.rd_idx = r_nxt[IW-1:0];
                end else begin
                    n_cur = outer_next[IW-1:0];
                    o_mem.rd_idx = outer_next[IW-1:0];
                end
            end
            ffha_pkg::S_DONE: begin
                o_res_valid = 1'b1;
            end
            default: begin
                o_req_ready = 1'b0;
            end
        endcase
    end

    assign o_status = r_status;
    assign o_region = r_region;

endmodule

`default_nettype wire

// ===== rtl/first_fit_heap_allocator.sv =====
`default_nettype none

// First-fit allocator over a pool of 64 region descriptors kept in one
// single-port-read RAM (one read, one write per cycle, registered read
// data). One request is worked at a time; every descriptor visited costs one
// RAM read. An allocate walks the free regions until the first fit; a free
// searches the outstanding list, then coalesces adjacent free regions by
// comparing each free region with the others. A result waits in an output
// register so the next beat may be accepted meanwhile. A register write
// reinitialises the lists at once, with no clearing pass.
module first_fit_heap_allocator (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire  [2:0]  paddr,
    input  wire  [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    input  wire         s_tvalid,
    output logic        s_tready,
    input  wire  [63:0] s_tdata,   // request_size[31:0], address[63:32]
    input  wire         s_tuser,   // action
    output logic        m_tvalid,
    input  wire         m_tready,
    output logic [39:0] m_tdata    // status[2:0], region_address[34:3], zero[39:35]
);

    logic [31:0] r_heap_base;
    logic [31:0] r_heap_size;
    logic        r_m_valid;
    logic [34:0] r_m_data;
    logic        cfg_wr;
    logic        res_valid;
    logic        res_ready;
    logic [2:0]  res_status;
    logic [31:0] res_region;
    ffha_pkg::t_mem_req mem_req;
    ffha_pkg::t_desc    mem_q;

    assign pready = 1'b1;
    assign cfg_wr = psel && penable && pwrite;
    assign prdata = paddr[2] ? r_heap_size : r_heap_base;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heap_base <= '0;
            r_heap_size <= 32'd65536;
        end else if (cfg_wr) begin
            if (paddr[2]) r_heap_size <= pwdata;
            else          r_heap_base <= pwdata;
        end
    end

    ffha_store u_store (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_init      (cfg_wr),
        .i_heap_base (r_heap_base),
        .i_heap_size (r_heap_size),
        .i_req       (mem_req),
        .o_q         (mem_q)
    );

    ffha_engine u_engine (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_init      (cfg_wr),
        .i_req_valid (s_tvalid),
        .o_req_ready (s_tready),
        .i_action    (s_tuser),
        .i_size      (s_tdata[31:0]),
        .i_addr      (s_tdata[63:32]),
        .o_res_valid (res_valid),
        .i_res_ready (res_ready),
        .o_status    (res_status),
        .o_region    (res_region),
        .o_mem       (mem_req),
        .i_q         (mem_q)
    );

    assign res_ready = !r_m_valid || m_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_m_valid <= 1'b0;
        end else if (res_ready) begin
            r_m_valid <= res_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (res_ready && res_valid) begin
            r_m_data <= {res_region, res_status};
        end
    end

    assign m_tvalid = r_m_valid;
    assign m_tdata  = {5'd0, r_m_data};

endmodule

`default_nettype wire

// ===== verif/tb_top.sv =====
`default_nettype none

module tb_top;

    typedef struct packed {
        logic        action;
        logic [31:0] req_size;
        logic [31:0] addr;
    } t_req;

    typedef struct packed {
        logic [2:0]  status;
        logic [31:0] region;
    } t_resp;

    localparam int NDESC = 64;
    localparam longint CYCLE_LIMIT = 50000000;

    logic        i_clk;
    logic        i_rst_n;
    logic        psel, penable, pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;
    logic        s_tvalid;
    logic        s_tready;
    logic [63:0] s_tdata;
    logic        s_tuser;
    logic        m_tvalid;
    logic        m_tready;
    logic [39:0] m_tdata;

    first_fit_heap_allocator dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
    );

    // allocator mirror
    logic [31:0] cfg_base, cfg_size;
    logic [31:0] pool_base [NDESC];
    logic [31:0] pool_size [NDESC];
    int          pool_link [NDESC];
    int          free_hd, out_hd, spare_hd;

    t_req  pending_reqs[$];
    t_resp expected_resps[$];
    logic [31:0] live_addrs[$];

    int errors = 0;
    int n_results = 0;
    int n_ok_alloc, n_ok_free;
    longint cycles = 0;
    bit tx_quiet, rx_quiet, rx_hold;
    int stall_cycles = 0;

    function automatic void rebuild_pool();
        for (int i = 0; i < NDESC; i++) begin
            pool_base[i] = '0;
            pool_size[i] = '0;
            pool_link[i] = (i + 1 < NDESC) ? i + 1 : NDESC;
        end
        pool_base[0] = cfg_base;
        pool_size[0] = cfg_size;
        pool_link[0] = NDESC;
        free_hd = 0;
        out_hd = NDESC;
        spare_hd = 1;
    endfunction

    function automatic void merge_free();
        int cur, cmp, prv, nxt;
        cur = free_hd;
        while (cur < NDESC) begin
            cmp = free_hd;
            prv = NDESC;
            while (cmp < NDESC) begin
                nxt = pool_link[cmp];
                if (cmp != cur && pool_base[cur] + pool_size[cur] == pool_base[cmp]) begin
                    pool_size[cur] = pool_size[cur] + pool_size[cmp];
                    if (prv < NDESC) pool_link[prv] = nxt;
                    else free_hd = nxt;
                    pool_link[cmp] = spare_hd;
                    spare_hd = cmp;
                end else begin
                    prv = cmp;
                end
                cmp = nxt;
            end
            cur = pool_link[cur];
        end
    endfunction

    function automatic t_resp allocator_outcome(t_req r);
        t_resp o;
        logic [33:0] need;
        int d, f, cur, prv;
        o = '{status: ffha_pkg::ST_OK, region: '0};
        if (r.action == ffha_pkg::ACT_ALLOC) begin
            need = ({2'b0, r.req_size} + 34'd3) & ~34'd3;
            if (r.req_size == 0 || need > 34'hFFFF_FFFF) begin
                o.status = ffha_pkg::ST_BAD_SIZE;
            end else if (spare_hd >= NDESC) begin
                o.status = ffha_pkg::ST_NO_SPARE;
            end else begin
                d = spare_hd;
                spare_hd = pool_link[d];
                f = free_hd;
                while (f < NDESC && {2'b0, pool_size[f]} <= need) f = pool_link[f];
                if (f >= NDESC) begin
                    pool_link[d] = spare_hd;
                    spare_hd = d;
                    o.status = ffha_pkg::ST_NO_FIT;
                end else begin
                    pool_base[d] = pool_base[f] + pool_size[f] - need[31:0];
                    pool_size[d] = need[31:0];
                    pool_link[d] = out_hd;
                    out_hd = d;
                    pool_size[f] = pool_size[f] - need[31:0];
                    o.region = pool_base[d];
                end
            end
        end else if (r.addr != 0) begin
            cur = out_hd;
            prv = NDESC;
            while (cur < NDESC && pool_base[cur] != r.addr) begin
                prv = cur;
                cur = pool_link[cur];
            end
            if (cur >= NDESC) begin
                o.status = ffha_pkg::ST_NOT_FOUND;
            end else begin
                if (prv < NDESC) pool_link[prv] = pool_link[cur];
                else out_hd = pool_link[cur];
                pool_link[cur] = free_hd;
                free_hd = cur;
                merge_free();
            end
        end
        return o;
    endfunction

    task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
        $display("MISMATCH %s: got %h expected %h at cycle %0d", what, got, want, cycles);
        errors++;
    endtask

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles > CYCLE_LIMIT) begin
            $display("Timeout with %0d beats still expected", expected_resps.size());
            $display("Some tests failed");
            $finish;
        end
    end

    // driver
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_tvalid && s_tready) begin
                expected_resps.push_back(allocator_outcome(pending_reqs.pop_front()));
            end
            if ((!s_tvalid || s_tready) ) begin
                if (pending_reqs.size() > ((s_tvalid && s_tready) ? 1 : 0) - 1 &&
                    pending_reqs.size() != 0 && (tx_quiet || $urandom_range(99) >= 33)) begin
                    s_tvalid <= 1'b1;
                    s_tdata  <= {pending_reqs[0].addr, pending_reqs[0].req_size};
                    s_tuser  <= pending_reqs[0].action;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge i_clk) begin
        t_resp want;
        if (i_rst_n) begin
            if (m_tvalid && m_tready) begin
                n_results++;
                if (expected_resps.size() == 0) begin
                    report_mismatch("unexpected beat", m_tdata[31:0], '0);
                end else begin
                    want = expected_resps.pop_front();
                    if (m_tdata[2:0] != want.status)
                        report_mismatch("status", {29'd0, m_tdata[2:0]},
                                        {29'd0, want.status});
                    if (m_tdata[34:3] != want.region)
                        report_mismatch("region_address", m_tdata[34:3], want.region);
                    if (want.status == ffha_pkg::ST_OK && want.region != 0)
                        live_addrs.push_back(want.region);
                end
            end
            if (rx_hold) begin
                m_tready <= 1'b0;
                stall_cycles <= stall_cycles + 1;
            end else begin
                m_tready <= rx_quiet || ($urandom_range(99) >= 33);
            end
        end
    end

    task automatic apb_write(input int idx, input logic [31:0] val);
        @(posedge i_clk);
        psel <= 1'b1; pwrite <= 1'b1; paddr <= 3'(idx * 4); pwdata <= val; penable <= 1'b0;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
        if (idx == 0) cfg_base = val;
        else cfg_size = val;
        rebuild_pool();
        live_addrs.delete();
    endtask

    task automatic drain();
        while (pending_reqs.size() != 0 || s_tvalid || expected_resps.size() != 0)
            @(posedge i_clk);
        repeat (2000) @(posedge i_clk);
    endtask

    function automatic void queue_alloc(logic [31:0] sz);
        pending_reqs.push_back('{action: ffha_pkg::ACT_ALLOC, req_size: sz, addr: $urandom});
    endfunction

    function automatic void queue_free(logic [31:0] a);
        pending_reqs.push_back('{action: ffha_pkg::ACT_FREE, req_size: $urandom, addr: a});
    endfunction

    function automatic logic [31:0] pick_size();
        case ($urandom_range(9))
            0: return $urandom;
            1: return 32'hFFFF_FFFF - $urandom_range(7);
            2, 3: return $urandom_range(1, 16);
            default: return $urandom_range(1, 3000);
        endcase
    endfunction

    // random phase: allocate and free with addresses guessed near the heap top or taken from live regions
    task automatic random_phase(input int n);
        logic [31:0] guess;
        for (int k = 0; k < n; k++) begin
            if ($urandom_range(1)) begin
                queue_alloc(pick_size());
            end else begin
                case ($urandom_range(5))
                    0: guess = $urandom;
                    1: guess = 0;
                    default: guess = cfg_base + cfg_size - 4 * $urandom_range(1, 64 * 128);
                endcase
                if (live_addrs.size() != 0 && $urandom_range(2) != 0)
                    guess = live_addrs[$urandom_range(live_addrs.size() - 1)];
                queue_free(guess);
            end
            if (pending_reqs.size() > 8) begin
                while (pending_reqs.size() > 2) @(posedge i_clk);
            end
        end
        while (pending_reqs.size() != 0) @(posedge i_clk);
    endtask

    initial begin
        tx_quiet = 0; rx_quiet = 0; rx_hold = 0;
        psel = 0; penable = 0; pwrite = 0; paddr = '0; pwdata = '0;
        s_tvalid = 0; s_tdata = '0; s_tuser = 0; m_tready = 0;
        cfg_base = 32'd0; cfg_size = 32'd65536;
        rebuild_pool();
        i_rst_n = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1;

        // directed
        queue_alloc(0);
        queue_alloc(32'hFFFF_FFFF);
        queue_alloc(32'hFFFF_FFFD);
        queue_alloc(1);
        queue_alloc(5);
        queue_alloc(65536);
        queue_alloc(65532);
        queue_free(0);
        queue_free(32'h1234_5678);
        queue_free(65536 - 4);
        queue_free(65536 - 12);
        for (int i = 0; i < 66; i++) queue_alloc(4);
        drain();

        // fill up while the receiver holds off
        apb_write(1, 32'd4096);
        rx_hold = 1;
        for (int i = 0; i < 12; i++) queue_alloc(8);
        while (stall_cycles < 400) @(posedge i_clk);
        rx_hold = 0;
        drain();

        apb_write(0, 32'hFFFF_F000);
        apb_write(1, 32'h0000_2000);
        queue_alloc(16);
        queue_free(32'hFFFF_F000 + 32'h2000 - 16);
        tx_quiet = 1; rx_quiet = 1;
        random_phase(200);
        tx_quiet = 0; rx_quiet = 0;
        drain();

        apb_write(0, 32'h0000_0000);
        apb_write(1, 32'hFFFF_FFFF);
        queue_alloc(32'hFFFF_FFF8);
        random_phase(400);
        drain();

        apb_write(0, $urandom & 32'hFFFF_FFFC);
        apb_write(1, 32'h0000_0000);
        random_phase(50);
        drain();

        apb_write(0, 32'h8000_0000);
        apb_write(1, 32'h0001_0000);
        random_phase(650);
        drain();

        apb_write(0, $urandom);
        apb_write(1, 32'h0000_4000 | ($urandom & 32'hFFF));
        random_phase(600);
        drain();

        $display("Run covered %0d results across seven heap settings, including a long sink stall",
                 n_results);
        $display("%0d mismatches, %0d cycles", errors, cycles);
        if (errors == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

`default_nettype wire

// ===== filelist.f =====
rtl/ffha_pkg.sv
rtl/ffha_ram.sv
rtl/ffha_store.sv
rtl/ffha_engine.sv
rtl/first_fit_heap_allocator.sv
verif/tb_top.sv
